// ===== rtl/core/markdown_line_block_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// markdown_line_block_classifier_macros
// Assertion macros for the markdown line block classifier.
// Each check is sampled on the rising clock edge and is off during reset.
// ----------------------------------------------------------------------------
`ifndef MARKDOWN_LINE_BLOCK_CLASSIFIER_MACROS_SVH
`define MARKDOWN_LINE_BLOCK_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define MLBC_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mlbc check failed");
`define MLBC_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mlbc next-cycle check failed");
`else
`define MLBC_CHECK(label, clk, rst, prop)
`define MLBC_CHECK_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/mlbc_pkg.sv =====
// ----------------------------------------------------------------------------
// mlbc_pkg
// Types, codes and constants of the markdown line block classifier.
// ----------------------------------------------------------------------------
package mlbc_pkg;

   localparam int MLBC_MAX_LINE_BYTES = 4096;
   localparam int CNT_W               = 12;
   localparam logic [CNT_W-1:0] COUNT_CAP = 12'd4095;

   // Scan phase of the current line
   typedef enum logic [2:0] {
      PH_INDENT = 3'd0,
      PH_BAR    = 3'd1,
      PH_HASH   = 3'd2,
      PH_QUOTE  = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // Line class codes
   typedef enum logic [2:0] {
      K_NEWLINE = 3'd0,
      K_PAR     = 3'd1,
      K_BAR     = 3'd2,
      K_HEADER  = 3'd3,
      K_QUOTE   = 3'd4
   } class_type;

   // Character codes
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;

   // Bar style codes
   localparam logic [1:0] STYLE_DASH  = 2'd0;
   localparam logic [1:0] STYLE_UNDER = 2'd1;
   localparam logic [1:0] STYLE_STAR  = 2'd2;
   localparam logic [1:0] STYLE_EQ    = 2'd3;

   // Map a bar style back to its mark character
   function automatic logic [7:0] bar_char(input logic [1:0] style);
      logic [7:0] c;
      case (style)
         STYLE_DASH:  c = CH_DASH;
         STYLE_UNDER: c = CH_UNDER;
         STYLE_STAR:  c = CH_STAR;
         default:     c = CH_EQ;
      endcase
      return c;
   endfunction

   // Add one to a count, holding at the cap
   function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v,
                                                input logic [CNT_W-1:0] cap);
      logic [CNT_W:0] s;
      s = {1'b0, v} + {{CNT_W{1'b0}}, 1'b1};
      return (s > {1'b0, cap}) ? cap : s[CNT_W-1:0];
   endfunction

endpackage

// ===== rtl/core/markdown_line_block_classifier.sv =====
// ----------------------------------------------------------------------------
// markdown_line_block_classifier
// Classifies each text line (newline, paragraph, bar, header, quote) from a
// byte stream and reports style, nesting level, indent and text span.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                  | handshake
//  req     | in        | req_char_code, req_line_end            | valid / stall
//  rsp     | out       | rsp_line_class .. rsp_text_length      | valid / stall
//
// One byte is taken every cycle unless the input stalls; the scan state advances in the same cycle.
// A result appears in the cycle after the transfer of a byte with line_end set.
// The result register is the only buffer: the input stalls only while a
// result is held and the output side stalls.
// Synchronous active-high reset clears the scan state and the result valid.
// ----------------------------------------------------------------------------
`include "markdown_line_block_classifier_macros.svh"

module markdown_line_block_classifier #(
   parameter int MAX_LINE_BYTES = mlbc_pkg::MLBC_MAX_LINE_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_char_code,
   input  logic                      req_line_end,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_line_class,
   output logic [1:0]                rsp_rule_style,
   output logic [mlbc_pkg::CNT_W-1:0] rsp_nest_level,
   output logic [mlbc_pkg::CNT_W-1:0] rsp_indent_width,
   output logic [mlbc_pkg::CNT_W-1:0] rsp_text_start,
   output logic [mlbc_pkg::CNT_W-1:0] rsp_text_length
);
   import mlbc_pkg::*;

   localparam logic [CNT_W-1:0] PosCap =
      (MAX_LINE_BYTES - 1 < 4095) ? CNT_W'(MAX_LINE_BYTES - 1) : COUNT_CAP;

   // scan state
   phase_type        phase_ff,  phase_in;
   logic [CNT_W-1:0] pos_ff,    pos_in;
   logic [CNT_W-1:0] indent_ff, indent_in;
   logic [CNT_W-1:0] mark_ff,   mark_in;
   logic [1:0]       bar_ff,    bar_in;
   logic [CNT_W-1:0] toff_ff,   toff_in;
   class_type        kind_ff,   kind_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       cls_ff,    cls_in;
   logic [1:0]       style_ff,  style_in;
   logic [CNT_W-1:0] level_ff,  level_in;
   logic [CNT_W-1:0] ind_ff,    ind_in;
   logic [CNT_W-1:0] tstart_ff, tstart_in;
   logic [CNT_W-1:0] tlen_ff,   tlen_in;

   logic req_xfer, rsp_xfer, end_xfer;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign rsp_xfer  = rsp_valid_ff & ~rsp_stall;
   assign end_xfer  = req_xfer & req_line_end;

   // Advance the scan on one byte and build the line result on its last byte
   always_comb begin
      logic [7:0]       c;
      logic             blank;
      logic             is_bar;
      logic [1:0]       bar_idx;
      logic             fall;
      logic [CNT_W-1:0] p_next;
      logic [CNT_W:0]   tab_sum;
      phase_type        ph;
      class_type        kd;
      logic [CNT_W-1:0] toff;

      c        = req_char_code;
      blank    = c inside {CH_SPACE, CH_TAB};
      fall     = 1'b0;
      p_next   = inc_sat(pos_ff, PosCap);
      tab_sum  = {1'b0, indent_ff | CNT_W'(3)} + {{CNT_W{1'b0}}, 1'b1};
      is_bar   = 1'b1;
      case (c)
         CH_DASH:  bar_idx = STYLE_DASH;
         CH_UNDER: bar_idx = STYLE_UNDER;
         CH_STAR:  bar_idx = STYLE_STAR;
         CH_EQ:    bar_idx = STYLE_EQ;
         default: begin
            bar_idx = STYLE_DASH;
            is_bar  = 1'b0;
         end
      endcase

      phase_in  = phase_ff;
      indent_in = indent_ff;
      mark_in   = mark_ff;
      bar_in    = bar_ff;
      toff_in   = toff_ff;
      kind_in   = kind_ff;
      pos_in    = p_next;

      case (phase_ff)
         PH_INDENT: begin
            if (c == CH_SPACE) begin
               indent_in = inc_sat(indent_ff, COUNT_CAP);
            end else if (c == CH_TAB) begin
               indent_in = (tab_sum > {1'b0, COUNT_CAP}) ? COUNT_CAP : tab_sum[CNT_W-1:0];
            end else if (indent_ff >= CNT_W'(4)) begin
               phase_in = PH_DONE;
               kind_in  = K_PAR;
               toff_in  = pos_ff;
            end else if (is_bar) begin
               phase_in = PH_BAR;
               bar_in   = bar_idx;
               mark_in  = CNT_W'(1);
            end else begin
               fall = 1'b1;
            end
         end
         PH_BAR: begin
            if (c == bar_char(bar_ff)) begin
               mark_in = inc_sat(mark_ff, COUNT_CAP);
            end else if (!blank) begin
               if (req_line_end && mark_ff >= CNT_W'(3)) begin
                  phase_in = PH_DONE;
                  kind_in  = K_BAR;
               end else begin
                  fall = 1'b1;
               end
            end
         end
         PH_HASH: begin
            if (c == CH_HASH) begin
               mark_in = inc_sat(mark_ff, COUNT_CAP);
            end else if (blank) begin
               phase_in = PH_DONE;
               kind_in  = K_HEADER;
               toff_in  = p_next;
            end else begin
               phase_in = PH_DONE;
               kind_in  = K_PAR;
               mark_in  = '0;
               toff_in  = pos_ff;
            end
         end
         PH_QUOTE: begin
            if (c == CH_GT) begin
               mark_in = inc_sat(mark_ff, COUNT_CAP);
            end else if (!blank) begin
               phase_in = PH_DONE;
               kind_in  = K_QUOTE;
               toff_in  = pos_ff;
            end
         end
         default: begin
         end
      endcase

      // examine the byte where the bar test broke or was not tried
      if (fall) begin
         if (c == CH_HASH) begin
            phase_in = PH_HASH;
            mark_in  = CNT_W'(1);
         end else if (c == CH_GT) begin
            phase_in = PH_QUOTE;
            mark_in  = CNT_W'(1);
         end else begin
            phase_in = PH_DONE;
            kind_in  = K_PAR;
            mark_in  = '0;
            toff_in  = pos_ff;
         end
      end

      // close out a scan that ran to the line end
      ph   = phase_in;
      kd   = kind_in;
      toff = toff_in;
      case (ph)
         PH_INDENT, PH_BAR: begin
            kd   = K_PAR;
            toff = p_next;
         end
         PH_HASH: begin
            kd   = K_HEADER;
            toff = p_next;
         end
         PH_QUOTE: begin
            kd   = K_QUOTE;
            toff = p_next;
         end
         default: begin
         end
      endcase

      cls_in    = kd;
      style_in  = STYLE_DASH;
      level_in  = '0;
      ind_in    = indent_in;
      tstart_in = toff;
      tlen_in   = (p_next >= toff) ? p_next - toff : '0;
      if (pos_ff == '0) begin
         cls_in    = K_NEWLINE;
         ind_in    = '0;
         tstart_in = '0;
         tlen_in   = '0;
      end else if (kd == K_BAR) begin
         style_in  = bar_in;
         tstart_in = '0;
         tlen_in   = '0;
      end else if (kd == K_HEADER || kd == K_QUOTE) begin
         level_in  = mark_in;
      end

      // fill on a last-byte transfer, drain on an output transfer
      if (end_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold the scan state; clear it after each last byte
   always_ff @(posedge clock) begin
      if (reset || end_xfer) begin
         phase_ff  <= PH_INDENT;
         pos_ff    <= '0;
         indent_ff <= '0;
         mark_ff   <= '0;
         bar_ff    <= STYLE_DASH;
         toff_ff   <= '0;
         kind_ff   <= K_PAR;
      end else if (req_xfer) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         indent_ff <= indent_in;
         mark_ff   <= mark_in;
         bar_ff    <= bar_in;
         toff_ff   <= toff_in;
         kind_ff   <= kind_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (end_xfer) begin
         cls_ff    <= cls_in;
         style_ff  <= style_in;
         level_ff  <= level_in;
         ind_ff    <= ind_in;
         tstart_ff <= tstart_in;
         tlen_ff   <= tlen_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_class   = cls_ff;
   assign rsp_rule_style   = style_ff;
   assign rsp_nest_level   = level_ff;
   assign rsp_indent_width = ind_ff;
   assign rsp_text_start   = tstart_ff;
   assign rsp_text_length  = tlen_ff;

   // a last-byte transfer always leaves a result and a cleared scan
   `MLBC_CHECK_NEXT(a_end_fills, clock, reset, end_xfer, rsp_valid_ff && pos_ff == '0)
   // a taken result with no new last byte leaves the output empty
   `MLBC_CHECK_NEXT(a_drain, clock, reset, rsp_xfer && !end_xfer, !rsp_valid_ff)
   // a bar result carries no level and no text span
   `MLBC_CHECK(a_bar_fields, clock, reset, !(rsp_valid_ff && cls_ff == K_BAR) || (level_ff == '0 && tstart_ff == '0 && tlen_ff == '0))
   // the input stalls only behind a held result
   `MLBC_CHECK(a_stall_cause, clock, reset, !req_stall || rsp_valid_ff)

endmodule
